// ===== rtl/cce_pkg.sv =====
// Shared types and constants for the configurable CRC-16 engine.
`timescale 1ns / 1ps

package cce_pkg;

  localparam int unsigned CRC_W  = 16;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned IDX_W  = 2;

  // Reset values of the CRC state and the configuration registers
  localparam logic [CRC_W-1:0] DEFAULT_POLY  = 16'h1021;
  localparam logic [CRC_W-1:0] DEFAULT_INIT  = 16'hFFFF;
  localparam logic             DEFAULT_RIGHT = 1'b0;
  localparam logic [CRC_W-1:0] CRC_RESET     = 16'hFFFF;

  // Configuration register indexes
  localparam logic [IDX_W-1:0] REG_POLY  = 2'd0;
  localparam logic [IDX_W-1:0] REG_INIT  = 2'd1;
  localparam logic [IDX_W-1:0] REG_RIGHT = 2'd2;

  typedef struct packed {
    logic [CRC_W-1:0] poly;
    logic [CRC_W-1:0] init;
    logic             shift_right;
  } cfg_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              first;
    logic              last;
  } in_item_t;

endpackage

// ===== rtl/cce_cfg.sv =====
// Configuration register file of the CRC-16 engine.
`timescale 1ns / 1ps

module cce_cfg import cce_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [IDX_W-1:0] cfg_index_i,
  input  logic [CRC_W-1:0] cfg_data_i,
  output cfg_t             cfg_o
);

  cfg_t cfg_d, cfg_q;

  // Always ready: a write is accepted and registered straight into cfg_q
  assign cfg_ready_o = 1'b1;

  // Decode the index; drop writes to unknown indexes
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_POLY:  cfg_d.poly        = cfg_data_i;
        REG_INIT:  cfg_d.init        = cfg_data_i;
        REG_RIGHT: cfg_d.shift_right = cfg_data_i[0];
        default:   cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.poly        <= DEFAULT_POLY;
      cfg_q.init        <= DEFAULT_INIT;
      cfg_q.shift_right <= DEFAULT_RIGHT;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/cce_fold.sv =====
// Combinational fold of one byte into a CRC-16, left or reflected mode.
`timescale 1ns / 1ps

module cce_fold import cce_pkg::*; (
  input  logic [CRC_W-1:0]  crc_i,
  input  logic [BYTE_W-1:0] data_i,
  input  logic [CRC_W-1:0]  poly_i,
  input  logic              shift_right_i,
  output logic [CRC_W-1:0]  crc_o
);

  // Mix the byte in, then run eight shift-and-conditional-XOR steps
  always_comb begin
    logic [CRC_W-1:0] c;
    logic             hit;
    if (shift_right_i) begin
      c = crc_i ^ {{(CRC_W-BYTE_W){1'b0}}, data_i};
    end else begin
      c = crc_i ^ {data_i, {(CRC_W-BYTE_W){1'b0}}};
    end
    for (int k = 0; k < BYTE_W; k++) begin
      if (shift_right_i) begin
        hit = c[0];
        c   = {1'b0, c[CRC_W-1:1]};
      end else begin
        hit = c[CRC_W-1];
        c   = {c[CRC_W-2:0], 1'b0};
      end
      if (hit) begin
        c = c ^ poly_i;
      end
    end
    crc_o = c;
  end

endmodule

// ===== rtl/configurable_crc16_engine_unit.sv =====
// Top level of the configurable CRC-16 engine: input register, fold, result register.
// A last byte's CRC is loaded into the result register as it leaves the input register.
// Throughput: one byte per cycle, set by the combinational eight-step fold, unless a last
// byte waits on a stalled result; the CRC state updates as each byte advances.
// Reset: asynchronous, active low; clears both valid flags, sets the CRC state to 0xFFFF
// and loads the configuration defaults (polynomial 0x1021, init 0xFFFF, left mode).
`timescale 1ns / 1ps

module configurable_crc16_engine_unit import cce_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  // byte input channel
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [BYTE_W-1:0] data_byte_i,
  input  logic              first_byte_i,
  input  logic              last_byte_i,
  // result channel
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [CRC_W-1:0]  crc_value_o,
  // configuration write channel
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [IDX_W-1:0]  cfg_index_i,
  input  logic [CRC_W-1:0]  cfg_data_i
);

  cfg_t             cfg;
  in_item_t         s1_d, s1_q;
  logic             s1_valid_d, s1_valid_q;
  logic [CRC_W-1:0] crc_d, crc_q;
  logic [CRC_W-1:0] res_d, res_q;
  logic             res_valid_d, res_valid_q;
  logic [CRC_W-1:0] fold_in, fold_out;
  logic             res_free, s1_adv, in_acc;

  cce_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Advance the input register when its byte gives no result or the result slot frees
  assign res_free   = !res_valid_q || !out_stall_i;
  assign s1_adv     = s1_valid_q && (!s1_q.last || res_free);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_acc     = in_valid_i && !in_stall_o;

  // Capture the incoming item
  always_comb begin
    s1_d       = s1_q;
    s1_valid_d = s1_valid_q;
    if (!in_stall_o) begin
      s1_valid_d = in_valid_i;
    end
    if (in_acc) begin
      s1_d.data  = data_byte_i;
      s1_d.first = first_byte_i;
      s1_d.last  = last_byte_i;
    end
  end

  // Start from init on a first byte, else from the running CRC
  assign fold_in = s1_q.first ? cfg.init : crc_q;

  cce_fold u_fold (
    .crc_i         (fold_in),
    .data_i        (s1_q.data),
    .poly_i        (cfg.poly),
    .shift_right_i (cfg.shift_right),
    .crc_o         (fold_out)
  );

  // Update the running CRC and load the result on a last byte
  always_comb begin
    crc_d       = crc_q;
    res_d       = res_q;
    res_valid_d = res_valid_q;
    if (!out_stall_i) begin
      res_valid_d = 1'b0;
    end
    if (s1_adv) begin
      crc_d = fold_out;
      if (s1_q.last) begin
        res_d       = fold_out;
        res_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
      crc_q       <= CRC_RESET;
    end else begin
      s1_valid_q  <= s1_valid_d;
      res_valid_q <= res_valid_d;
      crc_q       <= crc_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    s1_q  <= s1_d;
    res_q <= res_d;
  end

  assign out_valid_o = res_valid_q;
  assign crc_value_o = res_q;

  // A new result appears only after a last byte left the input register
  a_res_from_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid_q) |-> $past(s1_valid_q && s1_q.last))
    else $error("result raised without a last byte");

  // An empty input register never stalls the input
  a_no_idle_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid_q |-> !in_stall_o)
    else $error("input stalled with empty input register");

  // A byte without a result leaves a stalled result untouched
  a_mid_keeps_res : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && !s1_q.last && res_valid_q && out_stall_i) |=> $stable(res_q))
    else $error("stalled result changed by a middle byte");

  // The CRC state moves only when a byte leaves the input register
  a_crc_moves_on_adv : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_adv |=> $stable(crc_q))
    else $error("CRC state changed without a byte");

endmodule
